// ----- rtl/per_cpu_msi_vector_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-CPU MSI vector allocator
// Shared property shells: same-cycle and next-cycle implication, both
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_MSI_VECTOR_ALLOCATOR_DEFINES_SVH
`define PER_CPU_MSI_VECTOR_ALLOCATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PCMVA_ASSERT_IMPL(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PCMVA_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pcmva_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmva_pkg
// Sizes, field widths, codes and controller/datapath command types of the
// per-CPU MSI vector allocator.
// ----------------------------------------------------------------------------
package pcmva_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int NUM_CPUS  = 8;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CPU_SPAN  = 1 << CPU_IDX_W;
  localparam int ADDR_W    = CPU_IDX_W + SLOT_W;

  localparam int OP_W       = 2;
  localparam int IRQ_W      = 10;
  localparam int CPU_W      = 3;
  localparam int RANGE_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_RESERVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CPU_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSI_BASE = 1'd1;

  localparam logic [MASK_W-1:0] CPU_MASK_RESET = 8'd1;

  typedef struct packed {
    logic load;    // capture the input item
    logic eval;    // per-CPU free flags, range mask, table read
    logic sel;     // pick the CPU, check reserve conflict
    logic commit;  // update bitmaps and table, load the result
    logic clear;   // clear one table entry
  } pcmva_cmd_t;

  typedef struct packed {
    logic clear_last;  // clear pointer is on the last table entry
  } pcmva_stat_t;

endpackage

// ----- rtl/pcmva_dp.sv -----
// ----------------------------------------------------------------------------
// pcmva_dp
// Datapath: config registers, per-CPU slot bitmaps, irq table memory,
// first-free search, range mask and the result register.
// ----------------------------------------------------------------------------
module pcmva_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcmva_pkg::pcmva_cmd_t                cmd,
  output pcmva_pkg::pcmva_stat_t               stat,
  input  logic                                 cfg_we,
  input  logic [pcmva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcmva_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pcmva_pkg::OP_W-1:0]           in_op,
  input  logic [pcmva_pkg::IRQ_W-1:0]          in_irq_number,
  input  logic [pcmva_pkg::CPU_W-1:0]          in_target_cpu,
  input  logic [pcmva_pkg::RANGE_W-1:0]        in_range_start,
  input  logic [pcmva_pkg::RANGE_W-1:0]        in_range_end,
  output logic [pcmva_pkg::STATUS_W-1:0]       out_status,
  output logic [pcmva_pkg::IRQ_W-1:0]          out_result_irq,
  output logic [pcmva_pkg::CPU_W-1:0]          out_chosen_cpu
);
  import pcmva_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Slots that exist; spare bits of a non-power-of-two table never count.
  localparam logic [SLOT_SPAN-1:0] VALID_SLOTS = {SLOT_SPAN{1'b1}} >> (SLOT_SPAN - NUM_SLOTS);

  logic [MASK_W-1:0]    cpu_mask_r;
  logic [IRQ_W-1:0]     msi_base_r;

  logic [OP_W-1:0]      op_r;
  logic [IRQ_W-1:0]     irq_r;
  logic [CPU_W-1:0]     tcpu_r;
  logic [RANGE_W-1:0]   rs_r;
  logic [RANGE_W-1:0]   re_r;

  logic [SLOT_SPAN-1:0] taken_r   [CPU_SPAN];
  logic [SLOT_SPAN-1:0] taken_nxt [CPU_SPAN];

  logic [CPU_SPAN-1:0]  cpu_free_r, cpu_free_nxt;
  logic [SLOT_SPAN-1:0] range_mask_r, range_mask_nxt;
  logic [SLOT_W-1:0]    slot_r;
  logic                 loc_ok_r, loc_ok_nxt;
  logic [CPU_IDX_W-1:0] sel_cpu_r, sel_cpu_nxt;
  logic                 any_free_r;
  logic                 conflict_r, conflict_nxt;

  logic [IRQ_W-1:0]     mem [MEM_DEPTH];
  logic [IRQ_W-1:0]     rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [IRQ_W-1:0]     mem_wdata;
  logic [ADDR_W-1:0]    clr_addr_r;

  logic [CPU_SPAN-1:0]  enabled;
  logic [IRQ_W-1:0]     slot_diff;
  logic [SLOT_SPAN-1:0] free_vec;
  logic [SLOT_SPAN-1:0] low_free;
  logic [SLOT_W-1:0]    ff_slot;
  logic                 loc_taken;
  logic                 reg_hit;
  logic                 rsv_apply;

  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [IRQ_W-1:0]     rirq_r, rirq_nxt;
  logic [CPU_W-1:0]     ccpu_r, ccpu_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_mask_r <= CPU_MASK_RESET;
      msi_base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CPU_MASK) begin
        cpu_mask_r <= cfg_data[MASK_W-1:0];
      end
      if (cfg_index == CFG_MSI_BASE) begin
        msi_base_r <= cfg_data[IRQ_W-1:0];
      end
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      irq_r  <= in_irq_number;
      tcpu_r <= in_target_cpu;
      rs_r   <= in_range_start;
      re_r   <= in_range_end;
    end
  end

  always_comb begin
    for (int c = 0; c < CPU_SPAN; c++) begin
      enabled[c] = (c < NUM_CPUS) && cpu_mask_r[c];
    end
  end

  // Evaluate step
  always_comb begin
    for (int c = 0; c < CPU_SPAN; c++) begin
      cpu_free_nxt[c] = enabled[c] && (|(~taken_r[c] & VALID_SLOTS));
    end
    for (int s = 0; s < SLOT_SPAN; s++) begin
      range_mask_nxt[s] = (s < NUM_SLOTS) && (RANGE_W'(s) >= rs_r) && (RANGE_W'(s) <= re_r);
    end
  end

  assign slot_diff  = irq_r - msi_base_r;
  assign loc_ok_nxt = (slot_diff < IRQ_W'(NUM_SLOTS)) &&
                      ({1'b0, tcpu_r} < (CPU_W + 1)'(NUM_CPUS));
  assign rd_addr    = {tcpu_r[CPU_IDX_W-1:0], slot_diff[SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cpu_free_r   <= cpu_free_nxt;
      range_mask_r <= range_mask_nxt;
      slot_r       <= slot_diff[SLOT_W-1:0];
      loc_ok_r     <= loc_ok_nxt;
    end
  end

  // Select step: lowest CPU with a free slot, reserve overlap check
  always_comb begin
    sel_cpu_nxt  = '0;
    conflict_nxt = 1'b0;
    for (int c = CPU_SPAN - 1; c >= 0; c--) begin
      if (cpu_free_r[c]) begin
        sel_cpu_nxt = CPU_IDX_W'(c);
      end
    end
    for (int c = 0; c < CPU_SPAN; c++) begin
      if (enabled[c] && (|(taken_r[c] & range_mask_r))) begin
        conflict_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      sel_cpu_r  <= sel_cpu_nxt;
      any_free_r <= |cpu_free_r;
      conflict_r <= conflict_nxt;
    end
  end

  // Commit step: lowest free slot of the chosen CPU
  assign free_vec  = ~taken_r[sel_cpu_r] & VALID_SLOTS;
  assign low_free  = free_vec & (~free_vec + SLOT_SPAN'(1));
  assign loc_taken = taken_r[tcpu_r[CPU_IDX_W-1:0]][slot_r];

  always_comb begin
    ff_slot = '0;
    for (int s = 0; s < SLOT_SPAN; s++) begin
      if (low_free[s]) begin
        ff_slot = ff_slot | SLOT_W'(s);
      end
    end
  end

  assign reg_hit   = cmd.commit && (op_r == OP_REGISTER) && any_free_r;
  assign rsv_apply = cmd.commit && (op_r == OP_RESERVE) && !conflict_r;

  always_comb begin
    for (int c = 0; c < CPU_SPAN; c++) begin
      taken_nxt[c] = taken_r[c];
      if (rsv_apply && enabled[c]) begin
        taken_nxt[c] = taken_r[c] | range_mask_r;
      end
    end
    if (reg_hit) begin
      taken_nxt[sel_cpu_r][ff_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CPU_SPAN; c++) begin
      if (!rst_n) begin
        taken_r[c] <= '0;
      end else begin
        taken_r[c] <= taken_nxt[c];
      end
    end
  end

  always_comb begin
    status_nxt = ST_NONE;
    rirq_nxt   = '0;
    ccpu_nxt   = '0;
    unique case (op_r)
      OP_REGISTER: begin
        if (any_free_r) begin
          status_nxt = ST_OK;
          rirq_nxt   = {{(IRQ_W - SLOT_W){1'b0}}, ff_slot} + msi_base_r;
          ccpu_nxt   = CPU_W'(sel_cpu_r);
        end
      end
      OP_RESERVE: begin
        status_nxt = conflict_r ? ST_CONFLICT : ST_OK;
      end
      OP_LOCATE: begin
        if (loc_ok_r && loc_taken) begin
          status_nxt = ST_OK;
          rirq_nxt   = rd_data_r;
        end
      end
      default: begin
        status_nxt = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      rirq_r   <= rirq_nxt;
      ccpu_r   <= ccpu_nxt;
    end
  end

  // Table memory: one write port shared by clear and register, one read port
  assign mem_we    = cmd.clear || reg_hit;
  assign mem_waddr = cmd.clear ? clr_addr_r : {sel_cpu_r, ff_slot};
  assign mem_wdata = cmd.clear ? '0 : irq_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.eval) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  assign stat.clear_last = (clr_addr_r == {ADDR_W{1'b1}});

  assign out_status     = status_r;
  assign out_result_irq = rirq_r;
  assign out_chosen_cpu = ccpu_r;

endmodule

// ----- rtl/pcmva_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcmva_ctrl
// Sequencer: table clear after reset, then load / evaluate / select /
// commit per item, and the result valid flag.
// ----------------------------------------------------------------------------
`include "per_cpu_msi_vector_allocator_defines.svh"

module pcmva_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  pcmva_pkg::pcmva_stat_t stat,
  output pcmva_pkg::pcmva_cmd_t  cmd
);
  import pcmva_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_SEL    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register has room
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `PCMVA_ASSERT_NEXT(a_accept_starts_eval, clk, rst_n, in_valid && !in_stall, state_r == S_EVAL, "accepted item did not start evaluation")
  `PCMVA_ASSERT_NEXT(a_eval_then_sel, clk, rst_n, cmd.eval, cmd.sel, "select step did not follow evaluation")
  `PCMVA_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid_r, "committed result not presented")
  `PCMVA_ASSERT_IMPL(a_commit_has_room, clk, rst_n, cmd.commit, !out_valid_r || !out_stall, "result overwritten while stalled")

endmodule

// ----- rtl/per_cpu_msi_vector_allocator.sv -----
// ----------------------------------------------------------------------------
// per_cpu_msi_vector_allocator
// Per-CPU first-free MSI slot allocator with irq table: register, reserve
// and locate operations over one bitmap and one table per CPU.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   register an irq, reserve a slot range on all enabled CPUs, or locate the
//   irq stored for an irq number on one CPU. Every transfer yields exactly
//   one result transfer on the output channel (out_valid / out_stall).
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   cpu_mask (index 0) or msi_base (index 1); cfg_ready is always high.
// Timing:
//   An item runs through four controller states: capture, evaluate (per-CPU
//   free flags, range mask, table read), select (first CPU with room,
//   reserve overlap), commit (bitmap and table update, result load). The
//   result is registered at commit; the next item is taken only once the
//   commit is done, with no overlap between items.
// Reset:
//   Bitmaps and config clear at once; the irq table is then swept one entry
//   a cycle across its 512 entries (NUM_CPUS span x NUM_SLOTS span), with in_stall high.
// Back-pressure:
//   A result waits in the output register while out_stall is high; the next
//   item may be taken meanwhile, but its commit waits until the slot frees.
// ----------------------------------------------------------------------------
module per_cpu_msi_vector_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pcmva_pkg::OP_W-1:0]       in_op,
  input  logic [pcmva_pkg::IRQ_W-1:0]      in_irq_number,
  input  logic [pcmva_pkg::CPU_W-1:0]      in_target_cpu,
  input  logic [pcmva_pkg::RANGE_W-1:0]    in_range_start,
  input  logic [pcmva_pkg::RANGE_W-1:0]    in_range_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pcmva_pkg::STATUS_W-1:0]   out_status,
  output logic [pcmva_pkg::IRQ_W-1:0]      out_result_irq,
  output logic [pcmva_pkg::CPU_W-1:0]      out_chosen_cpu,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcmva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmva_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcmva_pkg::*;

  pcmva_cmd_t  cmd;
  pcmva_stat_t stat;

  // The user must issue config writes only while idle; the block does not enforce this and takes them every cycle.
  assign cfg_ready = 1'b1;

  pcmva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcmva_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_op),
    .in_irq_number  (in_irq_number),
    .in_target_cpu  (in_target_cpu),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .out_status     (out_status),
    .out_result_irq (out_result_irq),
    .out_chosen_cpu (out_chosen_cpu)
  );

endmodule

// ----- tb/per_cpu_msi_vector_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_msi_vector_allocator_test
// Self-checking bench for the per-CPU MSI vector allocator. A local image of
// the per-CPU bitmaps, the irq table and both config registers predicts the
// reply to every accepted request. Directed cases cover the corners, then
// random traffic runs under several mask/base settings, with bursty requests
// and a back-pressured reply channel.
// ----------------------------------------------------------------------------
module per_cpu_msi_vector_allocator_test;
  import pcmva_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASES        = 5;

  // The package only names the three defined operations.
  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IRQ_W-1:0]   irq;
    logic [CPU_W-1:0]   cpu;
    logic [RANGE_W-1:0] range_lo;
    logic [RANGE_W-1:0] range_hi;
  } vector_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IRQ_W-1:0]    irq;
    logic [CPU_W-1:0]    cpu;
  } vector_reply_t;

  // Shapes of receiver back-pressure.
  typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_PULSED, FLOW_CHOKED} flow_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op = '0;
  logic [IRQ_W-1:0]      in_irq_number = '0;
  logic [CPU_W-1:0]      in_target_cpu = '0;
  logic [RANGE_W-1:0]    in_range_start = '0;
  logic [RANGE_W-1:0]    in_range_end = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IRQ_W-1:0]      out_result_irq;
  logic [CPU_W-1:0]      out_chosen_cpu;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Image of the allocator: one bitmap and one irq table per CPU, plus config.
  logic [NUM_SLOTS-1:0] taken_map [NUM_CPUS];
  logic [IRQ_W-1:0]     owner_irq [NUM_CPUS][NUM_SLOTS];
  logic [MASK_W-1:0]    mask_q;
  logic [IRQ_W-1:0]     base_q;

  // Replies owed by the block, oldest first.
  vector_reply_t vector_replies_due[$];
  vector_reply_t reply_head;

  int mismatch_count = 0;
  int cycle_count = 0;
  int settings_used = 0;
  int op_seen [4] = '{default: 0};
  int status_seen [3] = '{default: 0};

  flow_style_t flow_style = FLOW_FREE;
  int          flow_span = 0;

  per_cpu_msi_vector_allocator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_irq_number  (in_irq_number),
    .in_target_cpu  (in_target_cpu),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_result_irq (out_result_irq),
    .out_chosen_cpu (out_chosen_cpu),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d replies outstanding", $time,
               vector_replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Apply one request to the image and return the reply it must produce.
  function automatic vector_reply_t apply_vector_op(vector_op_t req);
    vector_reply_t    rep;
    logic             found;
    logic             clash;
    logic [IRQ_W-1:0] offset;
    int               lo;
    int               hi;
    rep = '0;
    rep.status = ST_NONE;
    case (req.op)
      OP_REGISTER: begin
        // First enabled CPU with room wins; lowest free slot within it.
        found = 1'b0;
        for (int c = 0; c < NUM_CPUS; c++) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!found && mask_q[c] && !taken_map[c][s]) begin
              found = 1'b1;
              taken_map[c][s] = 1'b1;
              owner_irq[c][s] = req.irq;
              rep.status = ST_OK;
              rep.irq = IRQ_W'(s) + base_q;
              rep.cpu = CPU_W'(c);
            end
          end
        end
      end
      OP_RESERVE: begin
        rep.status = ST_OK;
        lo = int'(req.range_lo);
        hi = (int'(req.range_hi) >= NUM_SLOTS) ? NUM_SLOTS - 1 : int'(req.range_hi);
        if (lo <= hi) begin
          // All or nothing: any taken slot on any enabled CPU blocks the range.
          clash = 1'b0;
          for (int c = 0; c < NUM_CPUS; c++)
            for (int s = lo; s <= hi; s++)
              if (mask_q[c] && taken_map[c][s]) clash = 1'b1;
          if (clash) begin
            rep.status = ST_CONFLICT;
          end else begin
            for (int c = 0; c < NUM_CPUS; c++)
              for (int s = lo; s <= hi; s++)
                if (mask_q[c]) taken_map[c][s] = 1'b1;
          end
        end
      end
      OP_LOCATE: begin
        // Slot offset wraps at the irq width; the mask plays no part here.
        offset = req.irq - base_q;
        if (offset < NUM_SLOTS && int'(req.cpu) < NUM_CPUS &&
            taken_map[req.cpu][offset[SLOT_W-1:0]]) begin
          rep.status = ST_OK;
          rep.irq = owner_irq[req.cpu][offset[SLOT_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  function automatic vector_op_t vector_op(logic [OP_W-1:0] op, logic [IRQ_W-1:0] irq,
                                           logic [CPU_W-1:0] cpu,
                                           logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
    vector_op_t req;
    req.op = op;
    req.irq = irq;
    req.cpu = cpu;
    req.range_lo = lo;
    req.range_hi = hi;
    return req;
  endfunction

  // Drive one request at the falling edge and hold it until the transfer.
  // Valid stays high on return; the caller drops it when a gap follows.
  task automatic send_item(input vector_op_t req);
    vector_reply_t rep;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= req.op;
    in_irq_number  <= req.irq;
    in_target_cpu  <= req.cpu;
    in_range_start <= req.range_lo;
    in_range_end   <= req.range_hi;
    do @(posedge clk); while (in_stall);
    rep = apply_vector_op(req);
    vector_replies_due.push_back(rep);
    op_seen[req.op]++;
    status_seen[rep.status]++;
  endtask

  // Drop valid and hold off until every owed reply has come back.
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (vector_replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CPU_MASK) mask_q = data[MASK_W-1:0];
    else base_q = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reconfigure only once the block is idle. Upper data bits of the mask
  // write are noise the block must drop.
  task automatic set_allocation(input logic [MASK_W-1:0] mask, input logic [IRQ_W-1:0] base);
    logic [CFG_DATA_W-1:0] word;
    drain_replies();
    word = CFG_DATA_W'($urandom());
    word[MASK_W-1:0] = mask;
    write_register(CFG_CPU_MASK, word);
    write_register(CFG_MSI_BASE, base);
    settings_used++;
  endtask

  // Reset settings: CPU 0 only, base 0.
  task automatic test_register_and_locate();
    send_item(vector_op(OP_LOCATE, 10'd0, 3'd0, 6'd0, 6'd0));       // empty table
    send_item(vector_op(OP_REGISTER, 10'h3FF, 3'd7, 6'd63, 6'd63)); // slot 0
    send_item(vector_op(OP_REGISTER, 10'd0, 3'd0, 6'd0, 6'd0));     // slot 1
    send_item(vector_op(OP_LOCATE, 10'd0, 3'd0, 6'd0, 6'd0));
    send_item(vector_op(OP_LOCATE, 10'd1, 3'd0, 6'd0, 6'd0));
    send_item(vector_op(OP_LOCATE, 10'd0, 3'd7, 6'd0, 6'd0));       // other CPU empty
    send_item(vector_op(OP_LOCATE, 10'h3FF, 3'd0, 6'd0, 6'd0));     // far past table
    send_item(vector_op(OP_LOCATE, 10'd64, 3'd0, 6'd0, 6'd0));      // first slot past table
    send_item(vector_op(OP_UNDEFINED, 10'h3FF, 3'd7, 6'd63, 6'd63));
  endtask

  task automatic test_reserve_ranges();
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd5, 6'd2));      // empty range
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd2, 6'd5));
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd4, 6'd6));      // overlaps
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd60, 6'd63));    // top of table
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd63, 6'd63));
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd0, 6'd0));      // registered slot
    send_item(vector_op(OP_LOCATE, 10'd3, 3'd0, 6'd0, 6'd0));       // reserved, never written
    send_item(vector_op(OP_REGISTER, 10'h155, 3'd0, 6'd0, 6'd0));   // skips reserved run
  endtask

  task automatic test_config_edges();
    // No CPU enabled: register finds nothing, reserve is a no-op.
    set_allocation(8'h00, 10'h3FF);
    send_item(vector_op(OP_REGISTER, 10'h2AA, 3'd0, 6'd0, 6'd0));
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd10, 6'd12));
    send_item(vector_op(OP_LOCATE, 10'h3FF, 3'd0, 6'd0, 6'd0));     // slot 0 at top base
    send_item(vector_op(OP_LOCATE, 10'd5, 3'd0, 6'd0, 6'd0));       // wraps to slot 6
    set_allocation(8'hFF, 10'd1000);
    send_item(vector_op(OP_REGISTER, 10'h0F0, 3'd0, 6'd0, 6'd0));
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd8, 6'd9));      // every CPU
    send_item(vector_op(OP_REGISTER, 10'h30F, 3'd0, 6'd0, 6'd0));
    send_item(vector_op(OP_LOCATE, 10'd7, 3'd3, 6'd0, 6'd0));       // below base, unmapped
    send_item(vector_op(OP_LOCATE, 10'd1009, 3'd5, 6'd0, 6'd0));
  endtask

  // Mostly well-formed traffic: locates aimed at live slots, short reserve
  // ranges that leave room for registers, some empty and wild ranges.
  task automatic test_random_traffic();
    vector_op_t        req;
    logic [31:0]       noise;
    logic [MASK_W-1:0] mask;
    logic [IRQ_W-1:0]  base;
    int                pick;
    int                burst_left;
    int                c;
    int                s;
    burst_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin mask = 8'hFF; base = '0; end
        2:       begin mask = 8'h80; base = 10'h3FF; end
        4:       begin mask = MASK_W'($urandom_range(1, 255)); base = '0; end
        default: begin mask = MASK_W'($urandom_range(1, 255)); base = IRQ_W'($urandom()); end
      endcase
      set_allocation(mask, base);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause once mid-run until the reply queue is empty.
        if (phase == 1 && n == PHASE_ITEMS / 2) drain_replies();
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 9)) begin
              @(negedge clk);
              in_valid <= 1'b0;
            end
          end
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
        end
        noise = $urandom();
        req = noise[$bits(vector_op_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          req.op = OP_REGISTER;
        end else if (pick < 55) begin
          req.op = OP_RESERVE;
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            s = int'(req.range_lo) + $urandom_range(0, 3);
            req.range_hi = (s > NUM_SLOTS - 1) ? RANGE_W'(NUM_SLOTS - 1) : RANGE_W'(s);
          end else if (pick == 7) begin
            req.range_lo = RANGE_W'($urandom_range(1, 63));
            req.range_hi = RANGE_W'($urandom_range(0, int'(req.range_lo) - 1));
          end
        end else if (pick < 95) begin
          req.op = OP_LOCATE;
          if ($urandom_range(0, 3) != 0) begin
            // Aim at a live slot of a random CPU when it has one.
            c = $urandom_range(0, NUM_CPUS - 1);
            if (taken_map[c] != '0) begin
              s = $urandom_range(0, NUM_SLOTS - 1);
              while (!taken_map[c][s]) s = (s + 1) % NUM_SLOTS;
              req.cpu = CPU_W'(c);
              req.irq = IRQ_W'(s) + base_q;
            end
          end
        end else begin
          req.op = OP_UNDEFINED;
        end
        send_item(req);
        burst_left--;
      end
    end
  endtask

  // Fill one CPU to the brim, then keep asking for more.
  task automatic test_cpu_exhaustion();
    logic [MASK_W-1:0] mask;
    int                c;
    int                free_slots;
    c = $urandom_range(0, NUM_CPUS - 1);
    mask = '0;
    mask[c] = 1'b1;
    set_allocation(mask, IRQ_W'($urandom()));
    free_slots = NUM_SLOTS - $countones(taken_map[c]);
    repeat (free_slots + 3)
      send_item(vector_op(OP_REGISTER, IRQ_W'($urandom()), CPU_W'($urandom()),
                          6'd0, 6'd0));
    send_item(vector_op(OP_RESERVE, 10'd0, 3'd0, 6'd0, 6'd63));
    repeat (4)
      send_item(vector_op(OP_LOCATE, IRQ_W'($urandom_range(0, NUM_SLOTS - 1)) + base_q,
                          CPU_W'(c), 6'd0, 6'd0));
  endtask

  // Receiver back-pressure: switch style after each randomly drawn span.
  always @(negedge clk) begin
    if (flow_span == 0) begin
      flow_style = flow_style_t'($urandom_range(0, 3));
      flow_span = $urandom_range(16, 96);
    end
    flow_span = flow_span - 1;
    case (flow_style)
      FLOW_FREE:   out_stall <= 1'b0;
      FLOW_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
      FLOW_PULSED: out_stall <= ((flow_span % 5) < 2);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare every reply transfer with the oldest owed reply.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (vector_replies_due.size() == 0) begin
        $display("%0t: reply with none owed, expected nothing, actual status=%0d irq=%0d cpu=%0d",
                 $time, out_status, out_result_irq, out_chosen_cpu);
        mismatch_count++;
      end else begin
        reply_head = vector_replies_due.pop_front();
        if (out_status !== reply_head.status) begin
          $display("%0t: status expected %0d actual %0d", $time, reply_head.status,
                   out_status);
          mismatch_count++;
        end
        if (out_result_irq !== reply_head.irq) begin
          $display("%0t: result_irq expected %0d actual %0d", $time, reply_head.irq,
                   out_result_irq);
          mismatch_count++;
        end
        if (out_chosen_cpu !== reply_head.cpu) begin
          $display("%0t: chosen_cpu expected %0d actual %0d", $time, reply_head.cpu,
                   out_chosen_cpu);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Image starts like the block after reset.
    mask_q = CPU_MASK_RESET;
    base_q = '0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      taken_map[c] = '0;
      for (int s = 0; s < NUM_SLOTS; s++) owner_irq[c][s] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The table sweep after reset shows up as in_stall; send_item waits it out.
    test_register_and_locate();
    test_reserve_ranges();
    test_config_edges();
    test_random_traffic();
    test_cpu_exhaustion();
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (vector_replies_due.size() != 0) begin
      $display("%0t: %0d owed replies never arrived", $time, vector_replies_due.size());
      mismatch_count += vector_replies_due.size();
    end
    $display("Covered %0d register, %0d reserve, %0d locate, %0d undefined requests over %0d settings",
             op_seen[OP_REGISTER], op_seen[OP_RESERVE], op_seen[OP_LOCATE],
             op_seen[OP_UNDEFINED], settings_used);
    $display("Replies: %0d ok, %0d no slot or unmapped, %0d reserve conflicts",
             status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_CONFLICT]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcmva_pkg.sv
rtl/pcmva_dp.sv
rtl/pcmva_ctrl.sv
rtl/per_cpu_msi_vector_allocator.sv
tb/per_cpu_msi_vector_allocator_test.sv
